@@ rtl/mteg_pkg.sv @@
// Shared types, constants and the sine table function of the multi-tone excitation generator.
package mteg_pkg;

   localparam int DEFAULT_NUM_TONES       = 4;
   localparam int DEFAULT_SINE_TABLE_BITS = 10;

   localparam int TONE_REGS          = 4;
   localparam int PHASE_WIDTH        = 32;
   localparam int TONE_WORD_WIDTH    = 48;
   localparam int TONE_FIELD_WIDTH   = 16;
   localparam int HARMONIC_LSB       = 0;
   localparam int AMPLITUDE_LSB      = 16;
   localparam int PHASE_OFFSET_LSB   = 32;
   localparam int TONE_COUNT_WIDTH   = 3;
   localparam int SAMPLE_WIDTH       = 16;
   localparam int PRODUCT_WIDTH      = 32;
   localparam int TERM_WIDTH         = 17;
   localparam int DRIVE_WIDTH        = 20;
   localparam int SUM_WIDTH          = 22;
   localparam int CSR_INDEX_WIDTH    = 4;
   localparam int CSR_DATA_WIDTH     = 48;
   localparam int PHASE_QUEUE_DEPTH  = 2;
   localparam int RESULT_QUEUE_DEPTH = 4;
   localparam int RESULT_COUNT_WIDTH = $clog2(RESULT_QUEUE_DEPTH + 1);

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = 22'sd524287;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = -22'sd524288;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BASE_PHASE_STEP = 4'd0,
      CSR_TONE_0_WORD     = 4'd1,
      CSR_TONE_1_WORD     = 4'd2,
      CSR_TONE_2_WORD     = 4'd3,
      CSR_TONE_3_WORD     = 4'd4,
      CSR_TONES_IN_USE    = 4'd5,
      CSR_DRIVE_MODE      = 4'd6,
      CSR_DC_OFFSET       = 4'd7
   } csr_index_type;

   // Head of the phase queue as seen by the tone engine.
   typedef struct packed {
      logic                   valid;
      logic [PHASE_WIDTH-1:0] phase;
   } phase_beat_type;

   // One finished sample on its way into the result queue.
   typedef struct packed {
      logic                          valid;
      logic signed [DRIVE_WIDTH-1:0] drive_value;
      logic                          drive_is_voltage;
   } result_beat_type;

   // Sine of a 32-bit phase in Q1.15, from a polynomial fit evaluated in integers.
   function automatic logic signed [SAMPLE_WIDTH-1:0] sine_value(input logic [PHASE_WIDTH-1:0] phase);
      logic [1:0] quadrant;
      longint     x;
      longint     x2;
      longint     t1;
      longint     t2;
      longint     y;
      longint     v;
      quadrant = phase[31:30];
      x = longint'(phase[29:14]);
      if (quadrant[0]) begin
         x = 65536 - x;
      end
      x2 = (x * x) >>> 16;
      t1 = 84094 - ((9279 * x2) >>> 16);
      t2 = 205887 - ((x2 * t1) >>> 16);
      y  = (x * t2) >>> 17;
      v  = (y + 1) >>> 1;
      if (v > 32767) begin
         v = 32767;
      end
      if (quadrant[1]) begin
         v = -v;
      end
      return SAMPLE_WIDTH'(v);
   endfunction

endpackage

@@ rtl/mteg_front.sv @@
// Front end: accepts sample ticks, advances the base phase accumulator and queues the phases.
module mteg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   input  logic                              req_restart,
   output logic                              req_full,
   input  logic [mteg_pkg::PHASE_WIDTH-1:0]  base_phase_step,
   output mteg_pkg::phase_beat_type          head,
   input  logic                              head_pop
);
   import mteg_pkg::*;

   localparam int PTR_WIDTH   = (PHASE_QUEUE_DEPTH > 1) ? $clog2(PHASE_QUEUE_DEPTH) : 1;
   localparam int COUNT_WIDTH = $clog2(PHASE_QUEUE_DEPTH + 1);

   logic [PHASE_WIDTH-1:0] phase_acc_ff;
   logic [PHASE_WIDTH-1:0] phase_acc_in;
   logic [PHASE_WIDTH-1:0] mem_ff [PHASE_QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff;
   logic [PTR_WIDTH-1:0]   wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff;
   logic [PTR_WIDTH-1:0]   rd_ptr_in;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   accept;

   assign req_full = (count_ff == COUNT_WIDTH'(PHASE_QUEUE_DEPTH));
   assign accept   = req_push && !req_full;

   assign head.valid = (count_ff != '0);
   assign head.phase = mem_ff[rd_ptr_ff];

   always_comb begin
      phase_acc_in = (req_restart ? '0 : phase_acc_ff) + base_phase_step;
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      count_in     = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(PHASE_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (head_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(PHASE_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !head_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && head_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (accept) begin
            phase_acc_ff <= phase_acc_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_ptr_ff] <= phase_acc_in;
      end
   end

endmodule

@@ rtl/mteg_tone_engine.sv @@
// Back end: walks the enabled tones one per cycle through a multiply, sine lookup, scale and sum pipeline.
module mteg_tone_engine #(
   parameter int NUM_TONES       = mteg_pkg::DEFAULT_NUM_TONES,
   parameter int SINE_TABLE_BITS = mteg_pkg::DEFAULT_SINE_TABLE_BITS
) (
   input  logic                                                   clock,
   input  logic                                                   reset,
   input  mteg_pkg::phase_beat_type                               head,
   output logic                                                   head_pop,
   input  logic [NUM_TONES-1:0][mteg_pkg::TONE_WORD_WIDTH-1:0]    tone_words,
   input  logic [mteg_pkg::TONE_COUNT_WIDTH-1:0]                  tones_in_use,
   input  logic                                                   drive_mode,
   input  logic signed [mteg_pkg::SAMPLE_WIDTH-1:0]               dc_offset,
   input  logic [mteg_pkg::RESULT_COUNT_WIDTH-1:0]                result_count,
   output mteg_pkg::result_beat_type                              result
);
   import mteg_pkg::*;

   localparam int TABLE_DEPTH  = 2 ** SINE_TABLE_BITS;
   localparam int COUNT_WIDTH  = $clog2(NUM_TONES + 1);
   localparam int INDEX_WIDTH  = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
   localparam int RESERVE_WIDTH = RESULT_COUNT_WIDTH + 1;

   typedef logic signed [SAMPLE_WIDTH-1:0] sine_rom_type [TABLE_DEPTH];

   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         rom[i] = sine_value(PHASE_WIDTH'(i) << (PHASE_WIDTH - SINE_TABLE_BITS));
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

   // Issue sequencer.
   logic                          busy_ff;
   logic                          busy_in;
   logic [COUNT_WIDTH-1:0]        k_ff;
   logic [COUNT_WIDTH-1:0]        k_in;
   logic [PHASE_WIDTH-1:0]        phase_ff;
   logic [PHASE_WIDTH-1:0]        phase_in;
   logic [RESULT_COUNT_WIDTH-1:0] inflight_ff;
   logic [RESULT_COUNT_WIDTH-1:0] inflight_in;
   logic [RESERVE_WIDTH-1:0]      reserved;
   logic [COUNT_WIDTH-1:0]        tone_count;
   logic [COUNT_WIDTH-1:0]        last_k;
   logic                          use_tones;
   logic                          can_start;
   logic                          issue_valid;
   logic [PHASE_WIDTH-1:0]        issue_phase;
   logic [COUNT_WIDTH-1:0]        issue_k;
   logic                          issue_first;
   logic                          issue_last;
   logic [TONE_WORD_WIDTH-1:0]    issue_word;
   logic [47:0]                   harmonic_product;
   logic [PHASE_WIDTH-1:0]        tone_phase;

   // Stage A: table address. Stage B: sine sample. Stage C: scaled term.
   logic                              valid_a_ff;
   logic                              first_a_ff;
   logic                              last_a_ff;
   logic [SINE_TABLE_BITS-1:0]        addr_a_ff;
   logic [SINE_TABLE_BITS-1:0]        addr_a_in;
   logic signed [SAMPLE_WIDTH-1:0]    amp_a_ff;
   logic signed [SAMPLE_WIDTH-1:0]    amp_a_in;
   logic                              valid_b_ff;
   logic                              first_b_ff;
   logic                              last_b_ff;
   logic signed [SAMPLE_WIDTH-1:0]    amp_b_ff;
   logic signed [SAMPLE_WIDTH-1:0]    sine_b_ff;
   logic                              valid_c_ff;
   logic                              first_c_ff;
   logic                              last_c_ff;
   logic signed [PRODUCT_WIDTH-1:0]   prod_c_ff;
   logic signed [PRODUCT_WIDTH-1:0]   prod_c_in;

   // Sum stage.
   logic signed [SUM_WIDTH-1:0]  sum_ff;
   logic signed [SUM_WIDTH-1:0]  sum_in;
   logic signed [TERM_WIDTH-1:0] term;
   logic signed [SUM_WIDTH-1:0]  total;
   logic signed [SUM_WIDTH-1:0]  saturated;
   logic                         finalize;

   always_comb begin
      if ((TONE_COUNT_WIDTH + 1)'(tones_in_use) > (TONE_COUNT_WIDTH + 1)'(NUM_TONES)) begin
         tone_count = COUNT_WIDTH'(NUM_TONES);
      end else begin
         tone_count = COUNT_WIDTH'(tones_in_use);
      end
      use_tones = (tone_count != '0);
      last_k    = use_tones ? tone_count - 1'b1 : '0;
   end

   // An item starts only when a result queue slot is guaranteed for it.
   assign reserved  = RESERVE_WIDTH'(inflight_ff) + RESERVE_WIDTH'(result_count);
   assign can_start = head.valid && !busy_ff &&
                      (reserved < RESERVE_WIDTH'(RESULT_QUEUE_DEPTH));
   assign head_pop  = can_start;

   always_comb begin
      issue_valid = busy_ff || can_start;
      issue_phase = busy_ff ? phase_ff : head.phase;
      issue_k     = busy_ff ? k_ff : '0;
      issue_first = !busy_ff;
      issue_last  = (issue_k == last_k);
      issue_word  = tone_words[issue_k[INDEX_WIDTH-1:0]];

      busy_in  = busy_ff;
      k_in     = k_ff;
      phase_in = phase_ff;
      if (can_start) begin
         busy_in  = !issue_last;
         k_in     = COUNT_WIDTH'(1);
         phase_in = head.phase;
      end else if (busy_ff) begin
         busy_in = !issue_last;
         k_in    = k_ff + 1'b1;
      end

      inflight_in = inflight_ff;
      if (can_start && !finalize) begin
         inflight_in = inflight_ff + 1'b1;
      end else if (!can_start && finalize) begin
         inflight_in = inflight_ff - 1'b1;
      end
   end

   // Tone phase is harmonic times base phase plus the offset in the upper half, modulo 2^32.
   always_comb begin
      harmonic_product = 48'(issue_word[HARMONIC_LSB +: TONE_FIELD_WIDTH]) * 48'(issue_phase);
      tone_phase = harmonic_product[PHASE_WIDTH-1:0] +
                   {issue_word[PHASE_OFFSET_LSB +: TONE_FIELD_WIDTH], 16'h0000};
      addr_a_in  = tone_phase[PHASE_WIDTH-1 -: SINE_TABLE_BITS];
      // With no tone enabled a single zero term still carries the item through.
      amp_a_in   = use_tones ? $signed(issue_word[AMPLITUDE_LSB +: TONE_FIELD_WIDTH]) : '0;
      prod_c_in  = PRODUCT_WIDTH'(amp_b_ff * sine_b_ff);
   end

   // Floor of the Q15 product is an arithmetic shift, so the term is its upper bits.
   always_comb begin
      term      = prod_c_ff[PRODUCT_WIDTH-1 -: TERM_WIDTH];
      sum_in    = (first_c_ff ? '0 : sum_ff) + SUM_WIDTH'(term);
      total     = sum_in + (drive_mode ? SUM_WIDTH'(dc_offset) : '0);
      finalize  = valid_c_ff && last_c_ff;
      if (total > SUM_MAX) begin
         saturated = SUM_MAX;
      end else if (total < SUM_MIN) begin
         saturated = SUM_MIN;
      end else begin
         saturated = total;
      end
      result.valid            = finalize;
      result.drive_value      = saturated[DRIVE_WIDTH-1:0];
      result.drive_is_voltage = drive_mode;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         k_ff        <= '0;
         inflight_ff <= '0;
         valid_a_ff  <= 1'b0;
         valid_b_ff  <= 1'b0;
         valid_c_ff  <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         k_ff        <= k_in;
         inflight_ff <= inflight_in;
         valid_a_ff  <= issue_valid;
         valid_b_ff  <= valid_a_ff;
         valid_c_ff  <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      phase_ff   <= phase_in;
      first_a_ff <= issue_first;
      last_a_ff  <= issue_last;
      addr_a_ff  <= addr_a_in;
      amp_a_ff   <= amp_a_in;
      first_b_ff <= first_a_ff;
      last_b_ff  <= last_a_ff;
      amp_b_ff   <= amp_a_ff;
      sine_b_ff  <= SINE_ROM[addr_a_ff];
      first_c_ff <= first_b_ff;
      last_c_ff  <= last_b_ff;
      prod_c_ff  <= prod_c_in;
      if (valid_c_ff) begin
         sum_ff <= sum_in;
      end
   end

endmodule

@@ rtl/mteg_result_queue.sv @@
// Result queue holding finished samples until the consumer pops them.
module mteg_result_queue (
   input  logic                                          clock,
   input  logic                                          reset,
   input  mteg_pkg::result_beat_type                     push_beat,
   output logic [mteg_pkg::RESULT_COUNT_WIDTH-1:0]       count,
   output logic                                          rsp_empty,
   input  logic                                          rsp_pop,
   output logic signed [mteg_pkg::DRIVE_WIDTH-1:0]       rsp_drive_value,
   output logic                                          rsp_drive_is_voltage
);
   import mteg_pkg::*;

   localparam int PTR_WIDTH  = (RESULT_QUEUE_DEPTH > 1) ? $clog2(RESULT_QUEUE_DEPTH) : 1;
   localparam int ITEM_WIDTH = DRIVE_WIDTH + 1;

   logic [ITEM_WIDTH-1:0]         mem_ff [RESULT_QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]          wr_ptr_ff;
   logic [PTR_WIDTH-1:0]          wr_ptr_in;
   logic [PTR_WIDTH-1:0]          rd_ptr_ff;
   logic [PTR_WIDTH-1:0]          rd_ptr_in;
   logic [RESULT_COUNT_WIDTH-1:0] count_ff;
   logic [RESULT_COUNT_WIDTH-1:0] count_in;
   logic                          pop;
   logic [ITEM_WIDTH-1:0]         head_item;

   assign count                = count_ff;
   assign rsp_empty            = (count_ff == '0);
   assign pop                  = rsp_pop && !rsp_empty;
   assign head_item            = mem_ff[rd_ptr_ff];
   assign rsp_drive_value      = $signed(head_item[ITEM_WIDTH-1:1]);
   assign rsp_drive_is_voltage = head_item[0];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_beat.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_WIDTH'(RESULT_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_WIDTH'(RESULT_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_beat.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push_beat.valid && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_beat.valid) begin
         mem_ff[wr_ptr_ff] <= {push_beat.drive_value, push_beat.drive_is_voltage};
      end
   end

endmodule

@@ rtl/multi_tone_excitation_generator.sv @@
// Top level of the multi-tone excitation generator: configuration registers and the three stages.
//
// Each beat pushed on the req_ side is one sample tick. The 32-bit base phase accumulator is
// cleared first when req_restart is set, then advanced by base_phase_step; every enabled tone
// (tones 0 up to tones_in_use minus one, capped at NUM_TONES) contributes
// amplitude * sine(harmonic * phase + phase_offset) in Q15, the tone terms are summed, the DC
// offset is added in potentiostatic mode, and the total is saturated to 20 bits and handed out
// as one beat on the rsp_ side together with the drive type. The front end takes a tick while
// its phase queue is not full and buffers two phases; the back end runs one tone per cycle
// through a shared harmonic multiplier, the sine ROM and the amplitude multiplier, and starts
// the next tick once the last tone of the previous one has been issued and a result queue slot
// is free. A sample passes the table address, sine sample and scaled term registers and the
// sum into the result queue. Four finished samples can wait in the result queue while
// ticks are still being taken. The configuration port is always ready; registers are to be
// written only while no tick is being processed. Writes to an index beyond the register list
// are ignored.
module multi_tone_excitation_generator #(
   parameter int NUM_TONES       = mteg_pkg::DEFAULT_NUM_TONES,
   parameter int SINE_TABLE_BITS = mteg_pkg::DEFAULT_SINE_TABLE_BITS
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic                                     req_restart,
   output logic                                     rsp_empty,
   input  logic                                     rsp_pop,
   output logic signed [mteg_pkg::DRIVE_WIDTH-1:0]  rsp_drive_value,
   output logic                                     rsp_drive_is_voltage,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [mteg_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [mteg_pkg::CSR_DATA_WIDTH-1:0]      csr_data
);
   import mteg_pkg::*;

   logic                                          csr_write;
   logic [PHASE_WIDTH-1:0]                        base_phase_step_ff;
   logic [TONE_COUNT_WIDTH-1:0]                   tones_in_use_ff;
   logic                                          drive_mode_ff;
   logic signed [SAMPLE_WIDTH-1:0]                dc_offset_ff;
   logic [NUM_TONES-1:0][TONE_WORD_WIDTH-1:0]     tone_words;
   phase_beat_type                                phase_head;
   logic                                          phase_pop;
   result_beat_type                               result_beat;
   logic [RESULT_COUNT_WIDTH-1:0]                 result_count;

   // Every configuration beat is taken at once.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_phase_step_ff <= '0;
         tones_in_use_ff    <= '0;
         drive_mode_ff      <= 1'b0;
         dc_offset_ff       <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASE_PHASE_STEP: base_phase_step_ff <= csr_data[PHASE_WIDTH-1:0];
            CSR_TONES_IN_USE:    tones_in_use_ff    <= csr_data[TONE_COUNT_WIDTH-1:0];
            CSR_DRIVE_MODE:      drive_mode_ff      <= csr_data[0];
            CSR_DC_OFFSET:       dc_offset_ff       <= $signed(csr_data[SAMPLE_WIDTH-1:0]);
            default: begin
               // Tone words are written below; other indexes are ignored.
            end
         endcase
      end
   end

   // Only the first four tones have a register. Any further tone has zero amplitude and
   // therefore adds nothing to the sum.
   for (genvar t = 0; t < NUM_TONES; t++) begin : g_tone
      if (t < TONE_REGS) begin : g_reg
         logic [TONE_WORD_WIDTH-1:0] word_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               word_ff <= '0;
            end else if (csr_write &&
                         csr_index == CSR_INDEX_WIDTH'(int'(CSR_TONE_0_WORD) + t)) begin
               word_ff <= csr_data[TONE_WORD_WIDTH-1:0];
            end
         end
         assign tone_words[t] = word_ff;
      end else begin : g_zero
         assign tone_words[t] = '0;
      end
   end

   // Front end: phase accumulator and the queue of phases waiting for the tone engine.
   mteg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_restart     (req_restart),
      .req_full        (req_full),
      .base_phase_step (base_phase_step_ff),
      .head            (phase_head),
      .head_pop        (phase_pop)
   );

   // Back end: one tone per cycle through lookup, scaling and accumulation.
   mteg_tone_engine #(
      .NUM_TONES       (NUM_TONES),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_tone_engine (
      .clock        (clock),
      .reset        (reset),
      .head         (phase_head),
      .head_pop     (phase_pop),
      .tone_words   (tone_words),
      .tones_in_use (tones_in_use_ff),
      .drive_mode   (drive_mode_ff),
      .dc_offset    (dc_offset_ff),
      .result_count (result_count),
      .result       (result_beat)
   );

   // Finished samples wait here; the engine reserves a slot before it starts an item.
   mteg_result_queue u_result_queue (
      .clock                (clock),
      .reset                (reset),
      .push_beat            (result_beat),
      .count                (result_count),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_drive_value      (rsp_drive_value),
      .rsp_drive_is_voltage (rsp_drive_is_voltage)
   );

endmodule
